>>> design/rdq_pkg.sv
`timescale 1ns / 1ps
// Package for the reversible deque: operation and status codes, sequencer
// states and the command bundle between controller and datapath. No dependencies.
package rdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TOGGLE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_SEND
  } rdq_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
  } rdq_cmd_t;

endpackage

>>> design/reversible_deque_unit.sv
`timescale 1ns / 1ps
// Top level of the reversible deque: bounded double-ended queue on a ring
// store with a reverse flag. Depends on rdq_pkg, rdq_ctrl and rdq_dpath.
//
// One item is taken at a time and each gives one result. After an item is
// accepted, the index and count update with the store write, then the head and
// tail entries are read through a registered read, then the result is
// presented with m_tvalid, which stays high while m_tready is held low; the
// next item is accepted in the cycle after the result is taken. These steps
// are set by the sequencer and the registered read port of the ring store.
module reversible_deque_unit #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode[2:0], value[34:3], zero[39:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // front_value[31:0], back_value[63:32],
                                 // count[68:64], status[70:69], zero[71]
);
  import rdq_pkg::*;

  rdq_cmd_t            cmd;
  logic [VALUE_W-1:0]  front_value;
  logic [VALUE_W-1:0]  back_value;
  logic [COUNT_W-1:0]  count;
  logic [STATUS_W-1:0] status;

  rdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  rdq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (s_tdata[2:0]),
    .value       (s_tdata[34:3]),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .status      (status)
  );

  assign m_tdata = {1'b0, status, count, back_value, front_value};

endmodule

>>> design/rdq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the reversible deque: latch, update, read, present.
// Depends on rdq_pkg.
module rdq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output rdq_pkg::rdq_cmd_t cmd
);
  import rdq_pkg::*;

  rdq_state_t state;
  rdq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted item did not start an update");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && !m_tready) |=> (state == ST_SEND))
    else $error("result dropped while stalled");

endmodule

>>> design/rdq_dpath.sv
`timescale 1ns / 1ps
// Datapath of the reversible deque: ring store, head index, count, reverse
// flag and result registers. Depends on rdq_pkg.
module rdq_dpath #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rdq_pkg::rdq_cmd_t            cmd,
  input  logic [rdq_pkg::MODE_W-1:0]   mode,
  input  logic [rdq_pkg::VALUE_W-1:0]  value,
  output logic [rdq_pkg::VALUE_W-1:0]  front_value,
  output logic [rdq_pkg::VALUE_W-1:0]  back_value,
  output logic [rdq_pkg::COUNT_W-1:0]  count,
  output logic [rdq_pkg::STATUS_W-1:0] status
);
  import rdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  logic [DATA_WIDTH-1:0] ring_store [DEPTH];

  logic [MODE_W-1:0]     op_mode;
  logic [DATA_WIDTH-1:0] op_value;

  logic [IW-1:0]       first_index;
  logic [IW-1:0]       first_index_next;
  logic [CW-1:0]       element_count;
  logic [CW-1:0]       element_count_next;
  logic                reversed;
  logic                reversed_next;
  logic [STATUS_W-1:0] op_status;
  logic [STATUS_W-1:0] op_status_next;

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [IW-1:0]         slot_before;
  logic [IW-1:0]         slot_after;
  logic [IW-1:0]         slot_end;
  logic [IW-1:0]         slot_tail;
  logic [SW-1:0]         sum_end;
  logic [SW-1:0]         sum_tail;
  logic                  is_full;
  logic                  is_empty;
  logic signed [DATA_WIDTH-1:0] rd_head;
  logic signed [DATA_WIDTH-1:0] rd_tail;
  logic [VALUE_W-1:0]    head_v;
  logic [VALUE_W-1:0]    tail_v;

  assign is_full  = (element_count == CW'(DEPTH));
  assign is_empty = (element_count == '0);

  assign slot_before = (first_index == '0) ? IW'(DEPTH - 1) : first_index - IW'(1);
  assign slot_after  = (first_index == IW'(DEPTH - 1)) ? '0 : first_index + IW'(1);

  assign sum_end  = SW'(first_index) + SW'(element_count);
  assign slot_end = (sum_end >= SW'(DEPTH)) ? IW'(sum_end - SW'(DEPTH)) : IW'(sum_end);

  assign sum_tail  = SW'(first_index) + SW'(element_count) - SW'(1);
  assign slot_tail = is_empty ? first_index :
                     (sum_tail >= SW'(DEPTH)) ? IW'(sum_tail - SW'(DEPTH)) : IW'(sum_tail);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode;
      op_value <= DATA_WIDTH'(value);
    end
  end

  always_comb begin
    first_index_next   = first_index;
    element_count_next = element_count;
    reversed_next      = reversed;
    op_status_next     = STATUS_OK;
    wr_en              = 1'b0;
    wr_addr            = slot_end;
    case (op_mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (is_full) begin
          op_status_next = STATUS_PUSH_FULL;
        end else begin
          wr_en              = 1'b1;
          element_count_next = element_count + CW'(1);
          if ((op_mode == MODE_PUSH_BACK) == reversed) begin
            wr_addr          = slot_before;
            first_index_next = slot_before;
          end
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (is_empty) begin
          op_status_next = STATUS_POP_EMPTY;
        end else begin
          element_count_next = element_count - CW'(1);
          if ((op_mode == MODE_POP_BACK) == reversed) begin
            first_index_next = slot_after;
          end
        end
      end
      MODE_TOGGLE: begin
        reversed_next = !reversed;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_index   <= '0;
      element_count <= '0;
      reversed      <= 1'b0;
      op_status     <= STATUS_OK;
    end else if (cmd.exec) begin
      first_index   <= first_index_next;
      element_count <= element_count_next;
      reversed      <= reversed_next;
      op_status     <= op_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      ring_store[wr_addr] <= op_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_head <= ring_store[first_index];
      rd_tail <= ring_store[slot_tail];
    end
  end

  assign head_v = is_empty ? '0 : VALUE_W'(rd_head);
  assign tail_v = is_empty ? '0 : VALUE_W'(rd_tail);

  assign front_value = reversed ? tail_v : head_v;
  assign back_value  = reversed ? head_v : tail_v;
  assign count       = COUNT_W'(element_count);
  assign status      = op_status;

  assert property (@(posedge clk) disable iff (rst)
    element_count <= CW'(DEPTH))
    else $error("count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    32'(first_index) < 32'(DEPTH))
    else $error("head index out of range");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_empty && (op_mode == MODE_POP_BACK || op_mode == MODE_POP_FRONT))
    |=> (op_status == STATUS_POP_EMPTY && element_count == '0 &&
         $stable(first_index)))
    else $error("pop on empty changed the state");

endmodule

>>> test/tb_reversible_deque_unit.sv
`timescale 1ns / 1ps
// Testbench for reversible_deque_unit: a directed table, then biased random operations, checked
// field by field against fixed table views or an in-bench deque predictor. Depends on rdq_pkg and the design top.
module tb_reversible_deque_unit;
  import rdq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam int RING_SIZE     = DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 916;
  localparam int LONG_HOLD     = 200;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  back;
    logic [VALUE_W-1:0]  front;
  } deque_view_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic [4:0]         reps;
    logic               fixed;
    deque_view_t        view;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [39:0]         s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [71:0]         m_tdata;

  logic [VALUE_W-1:0]  ring_mirror [RING_SIZE];
  logic [3:0]          head_slot;
  logic [COUNT_W-1:0]  live_count;
  logic                flipped;

  deque_view_t         pending_views [$];
  deque_view_t         seen_view;
  deque_view_t         due_view;
  int                  mismatches;
  int                  cycles;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  bit                  hold_receiver;

  reversible_deque_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  localparam plan_row_t DIRECTED_PLAN [22] = '{
    '{MODE_PEEK,       32'h0000_0000, 5'd1,  1'b1,
      '{STATUS_OK,        5'd0, 32'h0000_0000, 32'h0000_0000}},
    '{MODE_POP_BACK,   32'h0000_0000, 5'd1,  1'b1,
      '{STATUS_POP_EMPTY, 5'd0, 32'h0000_0000, 32'h0000_0000}},
    '{MODE_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
      '{STATUS_POP_EMPTY, 5'd0, 32'h0000_0000, 32'h0000_0000}},
    '{MODE_TOGGLE,     32'h0000_0000, 5'd1,  1'b1,
      '{STATUS_OK,        5'd0, 32'h0000_0000, 32'h0000_0000}},
    '{MODE_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1,
      '{STATUS_POP_EMPTY, 5'd0, 32'h0000_0000, 32'h0000_0000}},
    '{MODE_PUSH_BACK,  32'h7fff_ffff, 5'd1,  1'b1,
      '{STATUS_OK,        5'd1, 32'h7fff_ffff, 32'h7fff_ffff}},
    '{MODE_TOGGLE,     32'h0000_0000, 5'd1,  1'b1,
      '{STATUS_OK,        5'd1, 32'h7fff_ffff, 32'h7fff_ffff}},
    '{MODE_PUSH_FRONT, 32'h8000_0000, 5'd1,  1'b1,
      '{STATUS_OK,        5'd2, 32'h7fff_ffff, 32'h8000_0000}},
    '{MODE_SPARE_6,    32'hffff_ffff, 5'd1,  1'b1,
      '{STATUS_OK,        5'd2, 32'h7fff_ffff, 32'h8000_0000}},
    '{MODE_SPARE_7,    32'hffff_ffff, 5'd1,  1'b1,
      '{STATUS_OK,        5'd2, 32'h7fff_ffff, 32'h8000_0000}},
    '{MODE_PUSH_BACK,  32'h0000_0000, 5'd1,  1'b0, '0},
    '{MODE_TOGGLE,     32'h0000_0000, 5'd1,  1'b0, '0},
    '{MODE_PUSH_FRONT, 32'hffff_ffff, 5'd1,  1'b0, '0},
    '{MODE_PUSH_BACK,  32'h0000_0001, 5'd1,  1'b0, '0},
    '{MODE_POP_BACK,   32'h1234_5678, 5'd1,  1'b0, '0},
    '{MODE_POP_FRONT,  32'h1234_5678, 5'd1,  1'b0, '0},
    '{MODE_TOGGLE,     32'h0000_0000, 5'd1,  1'b0, '0},
    '{MODE_PUSH_BACK,  32'ha5a5_a5a5, 5'd13, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'h5a5a_5a5a, 5'd1,  1'b0, '0},
    '{MODE_PUSH_BACK,  32'h0000_0001, 5'd1,  1'b0, '0},
    '{MODE_TOGGLE,     32'h0000_0000, 5'd1,  1'b0, '0},
    '{MODE_PUSH_FRONT, 32'hdead_beef, 5'd1,  1'b0, '0}
  };

  task automatic deque_step(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                            output deque_view_t view);
    logic [VALUE_W-1:0] head_v;
    logic [VALUE_W-1:0] tail_v;
    logic               at_tail;
    view.status = STATUS_OK;
    case (mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (live_count == COUNT_W'(RING_SIZE)) begin
          view.status = STATUS_PUSH_FULL;
        end else begin
          at_tail = (mode == MODE_PUSH_BACK) != flipped;
          if (at_tail) begin
            ring_mirror[4'(head_slot + live_count[3:0])] = value;
          end else begin
            head_slot = head_slot - 4'd1;
            ring_mirror[head_slot] = value;
          end
          live_count = live_count + 1'b1;
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (live_count == '0) begin
          view.status = STATUS_POP_EMPTY;
        end else begin
          at_tail = (mode == MODE_POP_BACK) != flipped;
          if (!at_tail) head_slot = head_slot + 4'd1;
          live_count = live_count - 1'b1;
        end
      end
      MODE_TOGGLE: flipped = !flipped;
      default: ;
    endcase
    head_v = '0;
    tail_v = '0;
    if (live_count != '0) begin
      head_v = ring_mirror[head_slot];
      tail_v = ring_mirror[4'(head_slot + live_count[3:0] - 4'd1)];
    end
    view.front = flipped ? tail_v : head_v;
    view.back  = flipped ? head_v : tail_v;
    view.count = live_count;
  endtask

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                           input logic fixed, input deque_view_t fixed_view);
    deque_view_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, value, mode};
    do @(posedge clk); while (!s_tready);
    deque_step(mode, value, predicted);
    pending_views.insert(pending_views.size(), fixed ? fixed_view : predicted);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, field, got, want);
    mismatches++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input int bias);
    int roll;
    int push_pct;
    int pop_pct;
    roll = $urandom_range(99);
    case (bias)
      0: begin push_pct = 70; pop_pct = 15; end
      1: begin push_pct = 20; pop_pct = 60; end
      default: begin push_pct = 45; pop_pct = 35; end
    endcase
    if (roll < push_pct) return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    if (roll < push_pct + pop_pct) return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
    if (roll < push_pct + pop_pct + 8) return MODE_TOGGLE;
    case ($urandom_range(2))
      0: return MODE_SPARE_6;
      1: return MODE_SPARE_7;
      default: return MODE_PEEK;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[reversible_deque_unit] ERROR");
    $finish;
  end

  initial begin
    int hold;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        m_tready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
        hold_receiver = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_view.front  = m_tdata[31:0];
      seen_view.back   = m_tdata[63:32];
      seen_view.count  = m_tdata[68:64];
      seen_view.status = m_tdata[70:69];
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected item", m_tdata[31:0], '0);
      end else begin
        due_view = pending_views[0];
        pending_views.delete(0);
        if (seen_view.front != due_view.front)
          report_mismatch("front_value", seen_view.front, due_view.front);
        if (seen_view.back != due_view.back)
          report_mismatch("back_value", seen_view.back, due_view.back);
        if (seen_view.count != due_view.count)
          report_mismatch("count", 32'(seen_view.count), 32'(due_view.count));
        if (seen_view.status != due_view.status)
          report_mismatch("status", 32'(seen_view.status), 32'(due_view.status));
      end
    end
  end

  initial begin
    int row;
    int k;
    int bias;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    mismatches    = 0;
    hold_receiver = 1'b0;
    tx_idle_pct   = 30;
    rx_idle_pct   = 50;
    head_slot     = '0;
    live_count    = '0;
    flipped       = 1'b0;
    for (k = 0; k < RING_SIZE; k++) ring_mirror[k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < $size(DIRECTED_PLAN); row++) begin
      for (k = 0; k < DIRECTED_PLAN[row].reps; k++) begin
        send_item(DIRECTED_PLAN[row].mode, DIRECTED_PLAN[row].value + VALUE_W'(k),
                  DIRECTED_PLAN[row].fixed, DIRECTED_PLAN[row].view);
      end
    end

    bias = 2;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 50;
        rx_idle_pct = 30;
      end
      if (k == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (k % 40 == 0) bias = $urandom_range(2);
      // starve the output so the input backs up
      if (k == 150 || k == 700) hold_receiver = 1'b1;
      // let every pending item drain before resuming
      if (k == 450 || k == 800) begin
        s_tvalid <= 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
      end
      send_item(pick_mode(bias), pick_value(), 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[reversible_deque_unit] OK");
    end else begin
      $display("[reversible_deque_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/rdq_pkg.sv
design/rdq_ctrl.sv
design/rdq_dpath.sv
design/reversible_deque_unit.sv
test/tb_reversible_deque_unit.sv
